FILE: sv/pdcc_pkg.sv
package pdcc_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int UNIT_FRAC_BITS  = 14;

   localparam int COORD_W = 32;
   localparam int UNIT_W  = 16;
   localparam int L2_W    = 2 * COORD_W;
   localparam int LEN_W   = L2_W / 2;
   localparam int Q_W     = UNIT_FRAC_BITS + 1;
   localparam int N_W     = UNIT_FRAC_BITS + 2;
   localparam int DOT_W   = N_W + UNIT_W + 2;
   localparam int C_W     = DOT_W - UNIT_FRAC_BITS;
   localparam int AP_W    = UNIT_W + C_W - UNIT_FRAC_BITS;
   localparam int V_W     = AP_W + 1;
   localparam int LV2_W   = 2 * V_W;
   localparam int LP_W    = LV2_W / 2;
   localparam int M_W     = V_W + 1;
   localparam int MP_W    = M_W + LEN_W + 1;

   localparam logic [LEN_W-1:0] LEN_EPS =
      LEN_W'(((64'd1 << COORD_FRAC_BITS) + 64'd5000) / 64'd10000);
   localparam logic [LV2_W-1:0] PERP_EPS =
      LV2_W'((64'd1 << (2 * UNIT_FRAC_BITS)) / 64'd10000);
   localparam logic [LV2_W-1:0] UNIT_ONE_SQ = LV2_W'(64'd1 << (2 * UNIT_FRAC_BITS));
   localparam logic [Q_W-1:0]   UNIT_ONE    = Q_W'(64'd1 << UNIT_FRAC_BITS);

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [UNIT_W-1:0]  axis_x;
      logic signed [UNIT_W-1:0]  axis_y;
      logic signed [UNIT_W-1:0]  axis_z;
      logic signed [UNIT_W-1:0]  cos_lower;
      logic signed [UNIT_W-1:0]  cos_upper;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] result_x;
      logic signed [COORD_W-1:0] result_y;
      logic signed [COORD_W-1:0] result_z;
      logic                      was_adjusted;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] p;
      logic [2:0][COORD_W-1:0] o;
      logic [2:0][UNIT_W-1:0]  ax;
      logic [UNIT_W-1:0]       lo;
      logic [UNIT_W-1:0]       hi;
      logic [2:0][COORD_W-1:0] d;
   } front_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] p;
      logic [2:0][COORD_W-1:0] o;
      logic [LEN_W-1:0]        len;
      logic                    ofs_short;
   } tail_type;

   typedef struct packed {
      tail_type               tail;
      logic [2:0][UNIT_W-1:0] ax;
      logic [UNIT_W-1:0]      lo;
      logic [UNIT_W-1:0]      hi;
   } div_side_type;

   typedef struct packed {
      tail_type             tail;
      logic [2:0][N_W-1:0]  n;
      logic [2:0][AP_W-1:0] ap;
      logic [2:0][V_W-1:0]  v;
   } mid_type;

   typedef struct packed {
      tail_type             tail;
      logic                 perp_ok;
      logic [2:0][N_W-1:0]  n;
      logic [2:0][AP_W-1:0] ap;
   } back_type;

endpackage

FILE: sv/pdcc_isqrt.sv
module pdcc_isqrt #(
   parameter int IN_W   = 64,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     in_value,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int STEPS = IN_W / 2;

   logic [IN_W-1:0]   rem_ff   [STEPS];
   logic [IN_W-1:0]   root_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];
   logic              valid_ff [STEPS];

   // One result bit per stage, from the top pair of input bits down.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [IN_W-1:0]   rem_prev;
      logic [IN_W-1:0]   root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [IN_W-1:0]   bit_val;
      logic [IN_W-1:0]   trial;
      logic [IN_W-1:0]   rem_in;
      logic [IN_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_value;
         assign root_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign bit_val = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * k);
      assign trial   = root_prev + bit_val;

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + bit_val;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1][IN_W/2-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

FILE: sv/pdcc_div.sv
module pdcc_div #(
   parameter int DEN_W  = 32,
   parameter int Q_W    = 15,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [DEN_W+Q_W-1:0]    in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic [Q_W-1:0]          out_quot,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int RW = DEN_W + Q_W;

   logic [RW-1:0]     rem_ff   [Q_W];
   logic [DEN_W-1:0]  den_ff   [Q_W];
   logic [Q_W-1:0]    quot_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];
   logic              valid_ff [Q_W];

   // Restoring division, one quotient bit per stage, most significant first.
   // The numerator is below den * 2^Q_W wherever the quotient is used.
   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [RW-1:0]     rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [RW-1:0]     shifted;
      logic [RW-1:0]     rem_in;
      logic [Q_W-1:0]    quot_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign shifted = {{Q_W{1'b0}}, den_prev} << (Q_W - 1 - k);

      always_comb begin
         if (rem_prev >= shifted) begin
            rem_in  = rem_prev - shifted;
            quot_in = quot_prev | ({{(Q_W-1){1'b0}}, 1'b1} << (Q_W - 1 - k));
         end else begin
            rem_in  = rem_prev;
            quot_in = quot_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_prev;
         quot_ff[k] <= quot_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

FILE: sv/point_direction_cone_clamp.sv
// Cone clamp of a point around a pivot. A request is taken in every cycle in
// which start is high; busy never rises, since the pipeline cannot stall. Each
// result appears on rsp_data with rsp_strobe high for one cycle, in request
// order, one per cycle at full rate. Its path runs through the bit-serial
// stages: a 32-stage square root of the offset length, a 15-stage divider
// per lane for the unit direction, two 23-stage square roots side by side
// for the perpendicular length and the sine, a second 15-stage divider per
// lane, and 14 registered arithmetic stages between them.
module point_direction_cone_clamp (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pdcc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output pdcc_pkg::rsp_type rsp_data
);

   import pdcc_pkg::*;

   localparam int RW1 = LEN_W + Q_W;
   localparam int RW2 = LP_W + Q_W;

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] x);
      logic [63:0] mag;
      mag = x[63] ? 64'(-x) : 64'(x);
      mag = (mag + (64'd1 << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
      return x[63] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [63:0] x);
      logic signed [63:0] hi_lim;
      logic signed [63:0] lo_lim;
      hi_lim = 64'sd2147483647;
      lo_lim = -64'sd2147483648;
      if (x > hi_lim) return COORD_W'(hi_lim);
      if (x < lo_lim) return COORD_W'(lo_lim);
      return x[COORD_W-1:0];
   endfunction

   assign busy = 1'b0;

   // Stage A: saturated offset.
   front_type a_front_in, a_front_ff;
   logic      a_valid_ff;

   always_comb begin
      logic signed [63:0] diff;
      a_front_in.p  = {req_data.point_z, req_data.point_y, req_data.point_x};
      a_front_in.o  = {req_data.origin_z, req_data.origin_y, req_data.origin_x};
      a_front_in.ax = {req_data.axis_z, req_data.axis_y, req_data.axis_x};
      a_front_in.lo = req_data.cos_lower;
      a_front_in.hi = req_data.cos_upper;
      for (int i = 0; i < 3; i++) begin
         diff = 64'($signed(a_front_in.p[i])) - 64'($signed(a_front_in.o[i]));
         a_front_in.d[i] = sat_coord(diff);
      end
   end

   // Stage B: squares. Stage C: squared length.
   front_type       b_front_ff, c_front_ff;
   logic [L2_W-1:0] b_sq_in [3];
   logic [L2_W-1:0] b_sq_ff [3];
   logic [L2_W-1:0] c_l2_in, c_l2_ff;
   logic            b_valid_ff, c_valid_ff;

   always_comb begin
      logic signed [L2_W-1:0] sq;
      for (int i = 0; i < 3; i++) begin
         sq = $signed(a_front_ff.d[i]) * $signed(a_front_ff.d[i]);
         b_sq_in[i] = $unsigned(sq);
      end
      c_l2_in = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_front_ff <= a_front_in;
      b_front_ff <= a_front_ff;
      b_sq_ff    <= b_sq_in;
      c_front_ff <= b_front_ff;
      c_l2_ff    <= c_l2_in;
   end

   // Offset length.
   logic             len_valid;
   logic [LEN_W-1:0] len_root;
   front_type        len_front;

   pdcc_isqrt #(.IN_W(L2_W), .SIDE_W($bits(front_type))) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_value  (c_l2_ff),
      .in_side   (c_front_ff),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_side  (len_front)
   );

   // Unit direction: |d| * one / len, rounded, per lane.
   div_side_type    dv_side;
   logic [RW1-1:0]  dv_num [3];
   logic [2:0]      dv_sign;

   always_comb begin
      logic [COORD_W-1:0] mag;
      dv_side.tail.p         = len_front.p;
      dv_side.tail.o         = len_front.o;
      dv_side.tail.len       = len_root;
      dv_side.tail.ofs_short = (len_root <= LEN_EPS);
      dv_side.ax             = len_front.ax;
      dv_side.lo             = len_front.lo;
      dv_side.hi             = len_front.hi;
      for (int i = 0; i < 3; i++) begin
         dv_sign[i] = len_front.d[i][COORD_W-1];
         mag        = dv_sign[i] ? (~len_front.d[i] + 1'b1) : len_front.d[i];
         dv_num[i]  = (RW1'(mag) << UNIT_FRAC_BITS) + RW1'(len_root >> 1);
      end
   end

   logic [2:0]         dq_valid;
   logic [Q_W-1:0]     dq_quot [3];
   logic [2:0]         dq_sign;
   div_side_type       dq_side;

   pdcc_div #(.DEN_W(LEN_W), .Q_W(Q_W), .SIDE_W(1 + $bits(div_side_type))) u_dir_div0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (len_valid),
      .in_num    (dv_num[0]),
      .in_den    (len_root),
      .in_side   ({dv_sign[0], dv_side}),
      .out_valid (dq_valid[0]),
      .out_quot  (dq_quot[0]),
      .out_side  ({dq_sign[0], dq_side})
   );

   for (genvar g = 1; g < 3; g++) begin : g_dir_div
      pdcc_div #(.DEN_W(LEN_W), .Q_W(Q_W), .SIDE_W(1)) u_dir_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (len_valid),
         .in_num    (dv_num[g]),
         .in_den    (len_root),
         .in_side   (dv_sign[g]),
         .out_valid (dq_valid[g]),
         .out_quot  (dq_quot[g]),
         .out_side  (dq_sign[g])
      );
   end

   // Stage E: clamped unit direction.
   logic [N_W-1:0] e_n_in [3];
   logic [N_W-1:0] e_n_ff [3];
   div_side_type   e_pay_ff;
   logic           e_valid_ff;

   always_comb begin
      logic [Q_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q         = (dq_quot[i] > UNIT_ONE) ? UNIT_ONE : dq_quot[i];
         e_n_in[i] = dq_sign[i] ? (N_W'(0) - N_W'(q)) : N_W'(q);
      end
   end

   // Stage F: axis products. Stage G: cosine.
   logic signed [N_W+UNIT_W-1:0] f_prod_in [3];
   logic signed [N_W+UNIT_W-1:0] f_prod_ff [3];
   logic [N_W-1:0]               f_n_ff [3];
   div_side_type                 f_pay_ff;
   logic                         f_valid_ff;

   logic signed [C_W-1:0] g_c_in, g_c_ff;
   logic [N_W-1:0]        g_n_ff [3];
   div_side_type          g_pay_ff;
   logic                  g_valid_ff;

   always_comb begin
      logic signed [DOT_W-1:0] dot;
      logic signed [63:0]      rnd;
      for (int i = 0; i < 3; i++) begin
         f_prod_in[i] = $signed(e_n_ff[i]) * $signed(e_pay_ff.ax[i]);
      end
      dot    = DOT_W'(f_prod_ff[0]) + DOT_W'(f_prod_ff[1]) + DOT_W'(f_prod_ff[2]);
      rnd    = round_shift(64'(dot));
      g_c_in = rnd[C_W-1:0];
   end

   // Stage H: axis times cosine, and the cosine clamped to its limits.
   logic signed [UNIT_W+C_W-1:0] h_axc_in [3];
   logic signed [UNIT_W+C_W-1:0] h_axc_ff [3];
   logic signed [UNIT_W-1:0]     h_c_in, h_c_ff;
   logic [N_W-1:0]               h_n_ff [3];
   div_side_type                 h_pay_ff;
   logic                         h_valid_ff;

   always_comb begin
      logic signed [C_W-1:0] c;
      for (int i = 0; i < 3; i++) begin
         h_axc_in[i] = $signed(g_pay_ff.ax[i]) * g_c_ff;
      end
      // The upper limit is applied first, so the lower one wins when they cross.
      c = g_c_ff;
      if (c > C_W'($signed(g_pay_ff.hi))) c = C_W'($signed(g_pay_ff.hi));
      if (c < C_W'($signed(g_pay_ff.lo))) c = C_W'($signed(g_pay_ff.lo));
      h_c_in = c[UNIT_W-1:0];
   end

   // Stage I: axial part and perpendicular part; squared cosine.
   logic [AP_W-1:0]           i_ap_in [3];
   logic signed [2*UNIT_W-1:0] i_axcl_in [3];
   logic signed [2*UNIT_W-1:0] i_axcl_ff [3];
   logic [V_W-1:0]            i_v_in [3];
   logic [V_W-1:0]            i_v_ff [3];
   logic signed [2*UNIT_W-1:0] i_csq_in, i_csq_ff;
   logic [N_W-1:0]            i_n_ff [3];
   div_side_type              i_pay_ff;
   logic                      i_valid_ff;

   always_comb begin
      logic signed [63:0] rnd;
      for (int i = 0; i < 3; i++) begin
         rnd        = round_shift(64'(h_axc_ff[i]));
         i_ap_in[i] = rnd[AP_W-1:0];
         i_v_in[i]  = V_W'($signed(h_n_ff[i])) - V_W'($signed(i_ap_in[i]));
         // The rebuilt direction takes its axial part from the clamped cosine.
         i_axcl_in[i] = $signed(h_pay_ff.ax[i]) * h_c_ff;
      end
      i_csq_in = h_c_ff * h_c_ff;
   end

   // Stage J: perpendicular squares and the sine argument.
   logic [LV2_W-1:0]  j_vsq_in [3];
   logic [LV2_W-1:0]  j_vsq_ff [3];
   logic [LV2_W-1:0]  j_sin_in, j_sin_ff;
   logic [N_W-1:0]    j_n_ff [3];
   logic [AP_W-1:0]   j_ap_in [3];
   logic [AP_W-1:0]   j_ap_ff [3];
   logic [V_W-1:0]    j_v_ff [3];
   div_side_type      j_pay_ff;
   logic              j_valid_ff;

   always_comb begin
      logic signed [2*V_W-1:0] sq;
      logic [LV2_W-1:0]        csq;
      logic signed [63:0]      rnd;
      for (int i = 0; i < 3; i++) begin
         sq          = $signed(i_v_ff[i]) * $signed(i_v_ff[i]);
         j_vsq_in[i] = LV2_W'($unsigned(sq));
         rnd         = round_shift(64'(i_axcl_ff[i]));
         j_ap_in[i]  = rnd[AP_W-1:0];
      end
      csq      = LV2_W'($unsigned(i_csq_ff));
      j_sin_in = (UNIT_ONE_SQ > csq) ? (UNIT_ONE_SQ - csq) : '0;
   end

   // Stage K: squared perpendicular length.
   logic [LV2_W-1:0]  k_lv2_in, k_lv2_ff;
   logic [LV2_W-1:0]  k_sin_ff;
   mid_type           k_mid_in, k_mid_ff;
   logic              k_valid_ff;

   always_comb begin
      k_lv2_in      = j_vsq_ff[0] + j_vsq_ff[1] + j_vsq_ff[2];
      k_mid_in.tail = j_pay_ff.tail;
      for (int i = 0; i < 3; i++) begin
         k_mid_in.n[i]  = j_n_ff[i];
         k_mid_in.ap[i] = j_ap_ff[i];
         k_mid_in.v[i]  = j_v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= &dq_valid;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
      end
      e_n_ff    <= e_n_in;
      e_pay_ff  <= dq_side;
      f_prod_ff <= f_prod_in;
      f_n_ff    <= e_n_ff;
      f_pay_ff  <= e_pay_ff;
      g_c_ff    <= g_c_in;
      g_n_ff    <= f_n_ff;
      g_pay_ff  <= f_pay_ff;
      h_axc_ff  <= h_axc_in;
      h_c_ff    <= h_c_in;
      h_n_ff    <= g_n_ff;
      h_pay_ff  <= g_pay_ff;
      i_axcl_ff <= i_axcl_in;
      i_v_ff    <= i_v_in;
      i_csq_ff  <= i_csq_in;
      i_n_ff    <= h_n_ff;
      i_pay_ff  <= h_pay_ff;
      j_vsq_ff  <= j_vsq_in;
      j_sin_ff  <= j_sin_in;
      j_n_ff    <= i_n_ff;
      j_ap_ff   <= j_ap_in;
      j_v_ff    <= i_v_ff;
      j_pay_ff  <= i_pay_ff;
      k_lv2_ff  <= k_lv2_in;
      k_sin_ff  <= j_sin_ff;
      k_mid_ff  <= k_mid_in;
   end

   // Perpendicular length and sine, side by side.
   logic             lp_valid, sn_valid;
   logic [LP_W-1:0]  lp_root, sn_root;
   mid_type          lp_mid;
   logic             sn_perp_ok;

   pdcc_isqrt #(.IN_W(LV2_W), .SIDE_W($bits(mid_type))) u_perp_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k_valid_ff),
      .in_value  (k_lv2_ff),
      .in_side   (k_mid_ff),
      .out_valid (lp_valid),
      .out_root  (lp_root),
      .out_side  (lp_mid)
   );

   pdcc_isqrt #(.IN_W(LV2_W), .SIDE_W(1)) u_sine_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k_valid_ff),
      .in_value  (k_sin_ff),
      .in_side   (k_lv2_ff > PERP_EPS),
      .out_valid (sn_valid),
      .out_root  (sn_root),
      .out_side  (sn_perp_ok)
   );

   // Stage L: |v| * sine for the rebuild division.
   logic [RW2-1:0]  l_prod_in [3];
   logic [RW2-1:0]  l_prod_ff [3];
   logic [2:0]      l_sign_in, l_sign_ff;
   logic [LP_W-1:0] l_lp_ff;
   back_type        l_back_in, l_back_ff;
   logic            l_valid_ff;

   always_comb begin
      logic [V_W-1:0] mag;
      l_back_in.tail    = lp_mid.tail;
      l_back_in.perp_ok = sn_perp_ok;
      l_back_in.n       = lp_mid.n;
      l_back_in.ap      = lp_mid.ap;
      for (int i = 0; i < 3; i++) begin
         l_sign_in[i] = lp_mid.v[i][V_W-1];
         mag          = l_sign_in[i] ? (~lp_mid.v[i] + 1'b1) : lp_mid.v[i];
         l_prod_in[i] = RW2'(mag) * RW2'(sn_root[Q_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
      end else begin
         l_valid_ff <= lp_valid & sn_valid;
      end
      l_prod_ff <= l_prod_in;
      l_sign_ff <= l_sign_in;
      l_lp_ff   <= lp_root;
      l_back_ff <= l_back_in;
   end

   logic [RW2-1:0] rb_num [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rb_num[i] = l_prod_ff[i] + RW2'(l_lp_ff >> 1);
      end
   end

   logic [2:0]     rq_valid;
   logic [Q_W-1:0] rq_quot [3];
   logic [2:0]     rq_sign;
   back_type       rq_back;

   pdcc_div #(.DEN_W(LP_W), .Q_W(Q_W), .SIDE_W(1 + $bits(back_type))) u_perp_div0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l_valid_ff),
      .in_num    (rb_num[0]),
      .in_den    (l_lp_ff),
      .in_side   ({l_sign_ff[0], l_back_ff}),
      .out_valid (rq_valid[0]),
      .out_quot  (rq_quot[0]),
      .out_side  ({rq_sign[0], rq_back})
   );

   for (genvar g = 1; g < 3; g++) begin : g_perp_div
      pdcc_div #(.DEN_W(LP_W), .Q_W(Q_W), .SIDE_W(1)) u_perp_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (l_valid_ff),
         .in_num    (rb_num[g]),
         .in_den    (l_lp_ff),
         .in_side   (l_sign_ff[g]),
         .out_valid (rq_valid[g]),
         .out_quot  (rq_quot[g]),
         .out_side  (rq_sign[g])
      );
   end

   // Stage M: rebuilt direction, or the old one when the perpendicular part vanishes.
   logic signed [M_W-1:0] m_dir_in [3];
   logic signed [M_W-1:0] m_dir_ff [3];
   tail_type              m_tail_ff;
   logic                  m_valid_ff;

   always_comb begin
      logic signed [M_W-1:0] qs;
      for (int i = 0; i < 3; i++) begin
         qs = rq_sign[i] ? (M_W'(0) - M_W'(rq_quot[i])) : M_W'(rq_quot[i]);
         if (rq_back.perp_ok) begin
            m_dir_in[i] = M_W'($signed(rq_back.ap[i])) + qs;
         end else begin
            m_dir_in[i] = M_W'($signed(rq_back.n[i]));
         end
      end
   end

   // Stage N: direction times length.
   logic signed [MP_W-1:0] n_mp_in [3];
   logic signed [MP_W-1:0] n_mp_ff [3];
   tail_type               n_tail_ff;
   logic                   n_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_mp_in[i] = m_dir_ff[i] * $signed({1'b0, m_tail_ff.len});
      end
   end

   // Stage O: add the pivot back and saturate, or pass the point through when the offset is too short.
   rsp_type rsp_in, rsp_ff;
   logic    rsp_strobe_ff;

   always_comb begin
      logic signed [63:0]        sum;
      logic [2:0][COORD_W-1:0]   res;
      for (int i = 0; i < 3; i++) begin
         sum    = round_shift(64'(n_mp_ff[i])) + 64'($signed(n_tail_ff.o[i]));
         res[i] = n_tail_ff.ofs_short ? n_tail_ff.p[i] : sat_coord(sum);
      end
      rsp_in.result_x     = res[0];
      rsp_in.result_y     = res[1];
      rsp_in.result_z     = res[2];
      rsp_in.was_adjusted = ~n_tail_ff.ofs_short;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff    <= 1'b0;
         n_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         m_valid_ff    <= &rq_valid;
         n_valid_ff    <= m_valid_ff;
         rsp_strobe_ff <= n_valid_ff;
      end
      m_dir_ff  <= m_dir_in;
      m_tail_ff <= rq_back.tail;
      n_mp_ff   <= n_mp_in;
      n_tail_ff <= m_tail_ff;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
